[hw/rtl/ctbr_pkg.sv]
// shared constants, types and helpers for the two-way byte-read cache
`default_nettype none

package ctbr_pkg;

  localparam int unsigned NUM_SETS_DEF  = 32;
  localparam int unsigned ADDR_BITS_DEF = 20;
  localparam int unsigned PADDR_W       = 21;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LANE_W        = 2;
  localparam int unsigned NUM_WAYS      = 2;
  localparam logic [BYTE_W-1:0] BYTE_ILLEGAL = 8'hFF;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_FILL    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  // write request from the lookup logic into the set store
  typedef struct packed {
    logic en;
    logic way;
  } fill_t;

  function automatic logic [BYTE_W-1:0] lane_byte(input logic [WORD_W-1:0] word,
                                                  input logic [LANE_W-1:0] lane);
    logic [BYTE_W-1:0] b;
    case (lane)
      2'd0:    b = word[7:0];
      2'd1:    b = word[15:8];
      2'd2:    b = word[23:16];
      2'd3:    b = word[31:24];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/two_way_cache_byte_read_core.sv]
// two-way set-associative byte-read cache with fill-order replacement
// an access is accepted at a start edge; busy is high for the next cycle while the
// set's tag/data entries, read at accept, are looked up, and done strobes the result in the cycle after
// a new access is not accepted while busy is high; in the lookup cycle a miss writes
// the fetched word back into the victim way of the set in the way memories
// reset clears valid and newest-way flops at once; tag/data memories are not cleared
`default_nettype none

module two_way_cache_byte_read_core #(
  parameter int unsigned NUM_SETS  = ctbr_pkg::NUM_SETS_DEF,
  parameter int unsigned ADDR_BITS = ctbr_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ctbr_pkg::PADDR_W-1:0]   phys_addr_i,
  input  wire logic [ctbr_pkg::WORD_W-1:0]    mem_word_i,
  output logic                                done_o,
  output logic [ctbr_pkg::BYTE_W-1:0]         byte_out_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned SET_W   = $clog2(NUM_SETS);
  localparam int unsigned EXT_W   = 33;
  localparam int unsigned TAG_LO  = ctbr_pkg::LANE_W + SET_W;
  localparam int unsigned TAG_W   = ADDR_BITS - TAG_LO;

  logic [EXT_W-1:0] addr_ext;
  logic             accept;
  logic             legal_d;
  logic [SET_W-1:0] set_d;
  logic [TAG_W-1:0] tag_d;

  logic                          busy_q;
  logic                          legal_q;
  logic [SET_W-1:0]              set_q;
  logic [TAG_W-1:0]              tag_q;
  logic [ctbr_pkg::LANE_W-1:0]   lane_q;
  logic [ctbr_pkg::WORD_W-1:0]   word_q;

  logic                          done_q;
  logic [ctbr_pkg::BYTE_W-1:0]   byte_q;
  ctbr_pkg::status_e             status_q;

  logic [ctbr_pkg::NUM_WAYS-1:0]                          rd_valid;
  logic                                                   rd_newest;
  logic [ctbr_pkg::NUM_WAYS-1:0][TAG_W-1:0]               rd_tag;
  logic [ctbr_pkg::NUM_WAYS-1:0][ctbr_pkg::WORD_W-1:0]    rd_data;
  ctbr_pkg::fill_t                                        fill;
  ctbr_pkg::fill_t                                        fill_gated;
  logic [ctbr_pkg::BYTE_W-1:0]                            lk_byte;
  ctbr_pkg::status_e                                      lk_status;

  assign accept   = start && !busy_q;
  assign addr_ext = EXT_W'(phys_addr_i);
  assign legal_d  = (addr_ext >> ADDR_BITS) == '0;
  assign set_d    = addr_ext[TAG_LO-1:ctbr_pkg::LANE_W];
  assign tag_d    = addr_ext[ADDR_BITS-1:TAG_LO];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      legal_q <= legal_d;
      set_q   <= set_d;
      tag_q   <= tag_d;
      lane_q  <= phys_addr_i[ctbr_pkg::LANE_W-1:0];
      word_q  <= mem_word_i;
    end
    if (busy_q) begin
      byte_q   <= lk_byte;
      status_q <= lk_status;
    end
  end

  ctbr_store #(
    .NUM_SETS (NUM_SETS),
    .TAG_W    (TAG_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_set_i    (set_d),
    .rd_valid_o  (rd_valid),
    .rd_newest_o (rd_newest),
    .rd_tag_o    (rd_tag),
    .rd_data_o   (rd_data),
    .wr_i        (fill_gated),
    .wr_set_i    (set_q),
    .wr_tag_i    (tag_q),
    .wr_data_i   (word_q)
  );

  ctbr_lookup #(
    .TAG_W (TAG_W)
  ) u_lookup (
    .legal_i    (legal_q),
    .tag_i      (tag_q),
    .lane_i     (lane_q),
    .mem_word_i (word_q),
    .valid_i    (rd_valid),
    .newest_i   (rd_newest),
    .tag_rd_i   (rd_tag),
    .data_rd_i  (rd_data),
    .fill_o     (fill),
    .byte_o     (lk_byte),
    .status_o   (lk_status)
  );

  // write back only in the lookup cycle
  always_comb begin
    fill_gated     = fill;
    fill_gated.en  = fill.en && busy_q;
  end

  assign busy       = busy_q;
  assign done_o     = done_q;
  assign byte_out_o = byte_q;
  assign status_o   = status_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start a lookup");

  a_busy_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("lookup did not deliver exactly one result");

  a_illegal_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ctbr_pkg::ST_ILLEGAL)) |-> (byte_out_o == ctbr_pkg::BYTE_ILLEGAL))
    else $error("illegal address result carries a data byte");

  a_illegal_no_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !legal_q) |-> !fill_gated.en)
    else $error("illegal address wrote the cache");

endmodule

`default_nettype wire

[hw/rtl/ctbr_store.sv]
// per-set storage: tag/data memories per way, valid and newest-way flops
`default_nettype none

module ctbr_store #(
  parameter int unsigned NUM_SETS = ctbr_pkg::NUM_SETS_DEF,
  parameter int unsigned TAG_W    = 13
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         rd_en_i,
  input  wire logic [$clog2(NUM_SETS)-1:0]                  rd_set_i,
  output logic      [ctbr_pkg::NUM_WAYS-1:0]                rd_valid_o,
  output logic                                              rd_newest_o,
  output logic      [ctbr_pkg::NUM_WAYS-1:0][TAG_W-1:0]     rd_tag_o,
  output logic      [ctbr_pkg::NUM_WAYS-1:0][ctbr_pkg::WORD_W-1:0] rd_data_o,
  input  wire ctbr_pkg::fill_t                              wr_i,
  input  wire logic [$clog2(NUM_SETS)-1:0]                  wr_set_i,
  input  wire logic [TAG_W-1:0]                             wr_tag_i,
  input  wire logic [ctbr_pkg::WORD_W-1:0]                  wr_data_i
);

  localparam int unsigned ENTRY_W = TAG_W + ctbr_pkg::WORD_W;

  logic [NUM_SETS-1:0][ctbr_pkg::NUM_WAYS-1:0] valid_q;
  logic [NUM_SETS-1:0]                         newest_q;
  logic [ctbr_pkg::NUM_WAYS-1:0]               rd_valid_q;
  logic                                        rd_newest_q;

  // valid and fill-order bits live in flops so reset clears them at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      newest_q    <= '0;
      rd_valid_q  <= '0;
      rd_newest_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_set_i][wr_i.way] <= 1'b1;
        newest_q[wr_set_i]          <= wr_i.way;
      end
      if (rd_en_i) begin
        rd_valid_q  <= valid_q[rd_set_i];
        rd_newest_q <= newest_q[rd_set_i];
      end
    end
  end

  assign rd_valid_o  = rd_valid_q;
  assign rd_newest_o = rd_newest_q;

  for (genvar g = 0; g < ctbr_pkg::NUM_WAYS; g++) begin : g_way
    logic [ENTRY_W-1:0] mem [NUM_SETS];
    logic [ENTRY_W-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.way == 1'(g))) begin
        mem[wr_set_i] <= {wr_tag_i, wr_data_i};
      end
      if (rd_en_i) begin
        rdata_q <= mem[rd_set_i];
      end
    end

    assign rd_tag_o[g]  = rdata_q[ENTRY_W-1:ctbr_pkg::WORD_W];
    assign rd_data_o[g] = rdata_q[ctbr_pkg::WORD_W-1:0];
  end

endmodule

`default_nettype wire

[hw/rtl/ctbr_lookup.sv]
// tag compare, victim choice and result byte selection for one set
`default_nettype none

module ctbr_lookup #(
  parameter int unsigned TAG_W = 13
) (
  input  wire logic                                            legal_i,
  input  wire logic [TAG_W-1:0]                                tag_i,
  input  wire logic [ctbr_pkg::LANE_W-1:0]                     lane_i,
  input  wire logic [ctbr_pkg::WORD_W-1:0]                     mem_word_i,
  input  wire logic [ctbr_pkg::NUM_WAYS-1:0]                   valid_i,
  input  wire logic                                            newest_i,
  input  wire logic [ctbr_pkg::NUM_WAYS-1:0][TAG_W-1:0]        tag_rd_i,
  input  wire logic [ctbr_pkg::NUM_WAYS-1:0][ctbr_pkg::WORD_W-1:0] data_rd_i,
  output ctbr_pkg::fill_t                                      fill_o,
  output logic [ctbr_pkg::BYTE_W-1:0]                          byte_o,
  output ctbr_pkg::status_e                                    status_o
);

  logic hit0, hit1, victim;

  // a matching tag on an invalid way is not a hit
  assign hit0 = valid_i[0] && (tag_rd_i[0] == tag_i);
  assign hit1 = valid_i[1] && (tag_rd_i[1] == tag_i);

  always_comb begin
    if (!valid_i[0]) begin
      victim = 1'b0;
    end else if (!valid_i[1]) begin
      victim = 1'b1;
    end else begin
      victim = ~newest_i;
    end
  end

  always_comb begin
    fill_o.en  = 1'b0;
    fill_o.way = victim;
    if (!legal_i) begin
      byte_o   = ctbr_pkg::BYTE_ILLEGAL;
      status_o = ctbr_pkg::ST_ILLEGAL;
    end else if (hit0) begin
      byte_o   = ctbr_pkg::lane_byte(data_rd_i[0], lane_i);
      status_o = ctbr_pkg::ST_HIT;
    end else if (hit1) begin
      byte_o   = ctbr_pkg::lane_byte(data_rd_i[1], lane_i);
      status_o = ctbr_pkg::ST_HIT;
    end else begin
      fill_o.en = 1'b1;
      byte_o    = ctbr_pkg::lane_byte(mem_word_i, lane_i);
      status_o  = ctbr_pkg::ST_FILL;
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_two_way_cache_byte_read_core.sv]
// testbench for the two-way byte-read cache: directed table, then random accesses
`timescale 1ns / 100ps

module tb_two_way_cache_byte_read_core;

  localparam int unsigned RAND_PER_PHASE = 210;
  localparam int unsigned CYCLE_LIMIT    = 60000;
  localparam int unsigned N_ROWS         = 22;

  typedef struct {
    logic [ctbr_pkg::PADDR_W-1:0] addr;
    logic [ctbr_pkg::WORD_W-1:0]  word;
    bit                           typed;
    logic [ctbr_pkg::BYTE_W-1:0]  exp_byte;
    ctbr_pkg::status_e            exp_status;
  } access_row_t;

  typedef struct {
    logic [ctbr_pkg::BYTE_W-1:0] rd_byte;
    ctbr_pkg::status_e           st;
  } read_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [ctbr_pkg::PADDR_W-1:0] phys_addr_i = '0;
  logic [ctbr_pkg::WORD_W-1:0]  mem_word_i = '0;
  logic                         done_o;
  logic [ctbr_pkg::BYTE_W-1:0]  byte_out_o;
  logic [1:0]                   status_o;

  // typed-in expectation that travels with the access on the bus
  bit                           cur_typed = 1'b0;
  logic [ctbr_pkg::BYTE_W-1:0]  cur_byte = '0;
  ctbr_pkg::status_e            cur_status = ctbr_pkg::ST_HIT;

  // predictor copy of the cache state
  logic                         line_valid [0:2*ctbr_pkg::NUM_SETS_DEF-1];
  logic [12:0]                  line_tag   [0:2*ctbr_pkg::NUM_SETS_DEF-1];
  logic [ctbr_pkg::WORD_W-1:0]  line_data  [0:2*ctbr_pkg::NUM_SETS_DEF-1];
  logic                         last_filled [0:ctbr_pkg::NUM_SETS_DEF-1];

  read_result_t       pending_reads [$];
  access_row_t        dir_rows [0:N_ROWS-1];
  int unsigned        idle_pct = 22;
  int unsigned        errors = 0;
  int unsigned        n_hit = 0;
  int unsigned        n_fill = 0;
  int unsigned        n_illegal = 0;
  int unsigned        cycle_count = 0;

  two_way_cache_byte_read_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .phys_addr_i (phys_addr_i),
    .mem_word_i  (mem_word_i),
    .done_o      (done_o),
    .byte_out_o  (byte_out_o),
    .status_o    (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void cache_lookup(input logic [ctbr_pkg::PADDR_W-1:0] a,
                                       input logic [ctbr_pkg::WORD_W-1:0] w,
                                       output logic [ctbr_pkg::BYTE_W-1:0] b,
                                       output ctbr_pkg::status_e s);
    logic [4:0]                  set_idx;
    logic [12:0]                 tag;
    logic [1:0]                  lane;
    logic                        victim;
    logic [ctbr_pkg::WORD_W-1:0] src;
    set_idx = a[6:2];
    tag     = a[19:7];
    lane    = a[1:0];
    if (a[20]) begin
      b = ctbr_pkg::BYTE_ILLEGAL;
      s = ctbr_pkg::ST_ILLEGAL;
    end else if (line_valid[{set_idx, 1'b0}] && line_tag[{set_idx, 1'b0}] == tag) begin
      src = line_data[{set_idx, 1'b0}];
      b   = src[lane*8 +: 8];
      s   = ctbr_pkg::ST_HIT;
    end else if (line_valid[{set_idx, 1'b1}] && line_tag[{set_idx, 1'b1}] == tag) begin
      src = line_data[{set_idx, 1'b1}];
      b   = src[lane*8 +: 8];
      s   = ctbr_pkg::ST_HIT;
    end else begin
      // invalid way first, way 0 before way 1, else the older fill
      if (!line_valid[{set_idx, 1'b0}]) victim = 1'b0;
      else if (!line_valid[{set_idx, 1'b1}]) victim = 1'b1;
      else victim = ~last_filled[set_idx];
      line_valid[{set_idx, victim}] = 1'b1;
      line_tag[{set_idx, victim}]   = tag;
      line_data[{set_idx, victim}]  = w;
      last_filled[set_idx]          = victim;
      b = w[lane*8 +: 8];
      s = ctbr_pkg::ST_FILL;
    end
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // check results, then record the transfer accepted at this edge
  always @(posedge clk_i) begin
    read_result_t exp_r;
    read_result_t got_r;
    if (rst_ni) begin
      if (done_o) begin
        case (status_o)
          ctbr_pkg::ST_HIT:  n_hit++;
          ctbr_pkg::ST_FILL: n_fill++;
          default:           n_illegal++;
        endcase
        if (pending_reads.size() == 0) begin
          flag_error($sformatf("unexpected result: byte %02h status %0d",
                               byte_out_o, status_o));
        end else begin
          exp_r = pending_reads.pop_front();
          if (byte_out_o !== exp_r.rd_byte)
            flag_error($sformatf("byte_out mismatch: expected %02h got %02h",
                                 exp_r.rd_byte, byte_out_o));
          if (status_o !== exp_r.st)
            flag_error($sformatf("status mismatch: expected %0d got %0d",
                                 exp_r.st, status_o));
        end
      end
      if (start && !busy) begin
        cache_lookup(phys_addr_i, mem_word_i, got_r.rd_byte, got_r.st);
        if (cur_typed) begin
          got_r.rd_byte = cur_byte;
          got_r.st      = cur_status;
        end
        pending_reads.push_back(got_r);
      end
    end
  end

  task automatic issue_access(input logic [ctbr_pkg::PADDR_W-1:0] a,
                              input logic [ctbr_pkg::WORD_W-1:0] w,
                              input bit typed, input logic [ctbr_pkg::BYTE_W-1:0] eb,
                              input ctbr_pkg::status_e es);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    phys_addr_i <= a;
    mem_word_i  <= w;
    cur_typed   <= typed;
    cur_byte    <= eb;
    cur_status  <= es;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [ctbr_pkg::PADDR_W-1:0] random_access_addr();
    int unsigned sel;
    logic [12:0] tag;
    logic [ctbr_pkg::PADDR_W-1:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      a = {1'b1, 20'($urandom)};
    end else if (sel < 25) begin
      a = {1'b0, 20'($urandom)};
    end else begin
      // small working set of tags so that sets see hits and evictions
      tag = ($urandom_range(0, 9) == 0) ? 13'h1FFF : 13'($urandom_range(0, 3));
      a = {1'b0, tag, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3))};
    end
    return a;
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_idle [0:2];
    for (int i = 0; i < 2*ctbr_pkg::NUM_SETS_DEF; i++) line_valid[i] = 1'b0;
    for (int i = 0; i < ctbr_pkg::NUM_SETS_DEF; i++) last_filled[i] = 1'b0;
    phase_idle = '{22, 51, 0};
    dir_rows = '{
      '{21'h000000, 32'h44332211, 1'b1, 8'h11, ctbr_pkg::ST_FILL},
      '{21'h000003, 32'hDEADBEEF, 1'b1, 8'h44, ctbr_pkg::ST_HIT},
      '{21'h100000, 32'h00000000, 1'b1, ctbr_pkg::BYTE_ILLEGAL, ctbr_pkg::ST_ILLEGAL},
      '{21'h1FFFFF, 32'hFFFFFFFF, 1'b1, ctbr_pkg::BYTE_ILLEGAL, ctbr_pkg::ST_ILLEGAL},
      '{21'h0FFFFF, 32'hA5FFFFFF, 1'b1, 8'hA5, ctbr_pkg::ST_FILL},
      '{21'h0FFFFC, 32'h00000000, 1'b1, 8'hFF, ctbr_pkg::ST_HIT},
      '{21'h000080, 32'h00000000, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h000081, 32'h12345678, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h000100, 32'hFFFFFFFF, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h000002, 32'hCAFEF00D, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h000102, 32'h00000000, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h000083, 32'h0BADBEEF, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h100003, 32'h11111111, 1'b1, ctbr_pkg::BYTE_ILLEGAL, ctbr_pkg::ST_ILLEGAL},
      '{21'h000001, 32'h22222222, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h000004, 32'h87654321, 1'b1, 8'h21, ctbr_pkg::ST_FILL},
      '{21'h000006, 32'h00000000, 1'b1, 8'h65, ctbr_pkg::ST_HIT},
      '{21'h0FFF80, 32'h5A5AC3C3, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h07FFFD, 32'h13579BDF, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h0FFFFD, 32'h00000000, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h155555, 32'h76543210, 1'b1, ctbr_pkg::BYTE_ILLEGAL, ctbr_pkg::ST_ILLEGAL},
      '{21'h0AAAAA, 32'h2468ACE0, 1'b0, 8'h00, ctbr_pkg::ST_HIT},
      '{21'h0AAAAA, 32'h00000000, 1'b0, 8'h00, ctbr_pkg::ST_HIT}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = phase_idle[0];
    for (int r = 0; r < N_ROWS; r++)
      issue_access(dir_rows[r].addr, dir_rows[r].word, dir_rows[r].typed,
                   dir_rows[r].exp_byte, dir_rows[r].exp_status);

    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < RAND_PER_PHASE; i++)
        issue_access(random_access_addr(), $urandom, 1'b0, 8'h00, ctbr_pkg::ST_HIT);
    end
    start <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (pending_reads.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_reads.size()));

    $display("covered %0d hits, %0d fills, %0d illegal addresses over three idle phases",
             n_hit, n_fill, n_illegal);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ctbr_pkg.sv
hw/rtl/ctbr_store.sv
hw/rtl/ctbr_lookup.sv
hw/rtl/two_way_cache_byte_read_core.sv
tb/sv/tb_two_way_cache_byte_read_core.sv
